// ===== rtl/wss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed sample statistics package
// Shared widths, register and request codes, and the controller/datapath
// command and status words.
// ----------------------------------------------------------------------------
package wss_pkg;

   localparam int WINDOW_DEPTH = 64;
   localparam int SAMPLE_BITS  = 16;

   localparam int ADDR_W     = $clog2(WINDOW_DEPTH);
   localparam int CNT_W      = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W      = SAMPLE_BITS + ADDR_W;
   localparam int AVG_W      = 7;
   localparam int TIME_W     = 32;
   localparam int DELTA_W    = 16;
   localparam int CMP_W      = (CNT_W > AVG_W) ? CNT_W : AVG_W;
   localparam int DIV_STEP_W = $clog2(SUM_W + 1);

   localparam int REQ_DATA_W = ((SAMPLE_BITS + DELTA_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((4 * SAMPLE_BITS + 7) / 8) * 8;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_AVG_WINDOW    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_DELAY = CSR_IDX_W'(1);

   localparam logic [AVG_W-1:0]  AVG_WINDOW_RESET    = AVG_W'(8);
   localparam logic [TIME_W-1:0] DISPLAY_DELAY_RESET = TIME_W'(1000);

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef struct packed {
      logic load;
      logic tick;
      logic store;
      logic walk;
      logic div_start;
      logic div_sel_all;
      logic run_save;
      logic all_save;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_tick;
      logic walk_done;
      logic div_busy;
      logic refresh;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/wss_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/wss_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sequential signed divider
// Restoring division of a signed sum by an unsigned count, one quotient bit
// per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module wss_div (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   input  wire logic signed [wss_pkg::SUM_W-1:0]         dividend,
   input  wire logic        [wss_pkg::CNT_W-1:0]         divisor,
   output logic                                          busy,
   output logic signed      [wss_pkg::SAMPLE_BITS-1:0]   quotient
);
   import wss_pkg::*;

   logic [SUM_W-1:0]      quo_ff, quo_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      den_ff, den_in;
   logic                  neg_ff, neg_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [CNT_W:0]        rem_shift;
   logic [CNT_W:0]        rem_sub;
   logic [SUM_W-1:0]      q_signed;

   always_comb begin
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      neg_in    = neg_ff;
      step_in   = step_ff;
      rem_shift = {rem_ff, quo_ff[SUM_W-1]};
      rem_sub   = rem_shift - {1'b0, den_ff};
      if (start) begin
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         rem_in  = '0;
         den_in  = divisor;
         step_in = DIV_STEP_W'(SUM_W);
      end else if (step_ff != '0) begin
         if (rem_shift >= {1'b0, den_ff}) begin
            rem_in = rem_sub[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign busy     = (step_ff != '0);
   assign q_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient = q_signed[SAMPLE_BITS-1:0];

endmodule
`default_nettype wire

// ===== rtl/wss_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed sample statistics datapath
// Sample ring, window walk with sums, minimum and maximum, shared divider,
// time keeping, configuration registers and the result register.
// ----------------------------------------------------------------------------
module wss_dpath (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire wss_pkg::cmd_type                        cmd,
   output wss_pkg::status_type                          status,
   input  wire logic                                    req_type,
   input  wire logic signed [wss_pkg::SAMPLE_BITS-1:0]  req_sample,
   input  wire logic        [wss_pkg::DELTA_W-1:0]      req_delta,
   input  wire logic                                    csr_we,
   input  wire logic        [wss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic        [wss_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                                         rsp_tvalid,
   input  wire logic                                    rsp_tready,
   output logic             [wss_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                                         rsp_tuser
);
   import wss_pkg::*;

   logic [AVG_W-1:0]  avg_window_ff, avg_window_in;
   logic [TIME_W-1:0] delay_ff, delay_in;

   logic                          type_ff, type_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [DELTA_W-1:0]            delta_ff, delta_in;

   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  pushes_ff, pushes_in;
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic              refresh_ff, refresh_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              pend_ff, pend_in;
   logic [CNT_W-1:0]  pend_idx_ff, pend_idx_in;

   logic signed [SUM_W-1:0]       sum_run_ff, sum_run_in;
   logic signed [SUM_W-1:0]       sum_all_ff, sum_all_in;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in;
   logic signed [SAMPLE_BITS-1:0] max_ff, max_in;

   logic signed [SAMPLE_BITS-1:0] last_avg_ff, last_avg_in;
   logic signed [SAMPLE_BITS-1:0] shown_avg_ff, shown_avg_in;
   logic signed [SAMPLE_BITS-1:0] shown_min_ff, shown_min_in;
   logic signed [SAMPLE_BITS-1:0] shown_max_ff, shown_max_in;
   logic                          updated_ff, updated_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   logic [CNT_W-1:0]  count_inc;
   logic [CNT_W-1:0]  pushes_inc;
   logic [CNT_W-1:0]  n_calc;
   logic [ADDR_W-1:0] pos_next;
   logic [CNT_W:0]    addr_calc;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_go;
   logic [TIME_W:0]   time_sum;

   logic signed [SAMPLE_BITS-1:0] rd_data;
   logic signed [SUM_W-1:0]       s_ext;
   logic signed [SUM_W-1:0]       div_dividend;
   logic [CNT_W-1:0]              div_divisor;
   logic                          div_busy;
   logic signed [SAMPLE_BITS-1:0] div_q;

   wss_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (pos_next),
      .wr_data (sample_ff),
      .rd_en   (rd_go),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign div_dividend = cmd.div_sel_all ? sum_all_ff : sum_run_ff;
   assign div_divisor  = cmd.div_sel_all ? count_ff : n_ff;

   wss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_q)
   );

   always_comb begin
      count_inc  = (count_ff < CNT_W'(WINDOW_DEPTH)) ? count_ff + 1'b1 : count_ff;
      pushes_inc = pushes_ff + 1'b1;
      n_calc     = (CMP_W'(avg_window_ff) > CMP_W'(count_inc)) ? count_inc
                                                               : CNT_W'(avg_window_ff);
      pos_next   = (pos_ff == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
      addr_calc  = ((CNT_W+1)'(pos_ff) >= (CNT_W+1)'(rd_idx_ff))
                 ? (CNT_W+1)'(pos_ff) - (CNT_W+1)'(rd_idx_ff)
                 : (CNT_W+1)'(pos_ff) + (CNT_W+1)'(WINDOW_DEPTH) - (CNT_W+1)'(rd_idx_ff);
      rd_addr    = addr_calc[ADDR_W-1:0];
      rd_go      = cmd.walk && (rd_idx_ff < len_ff);
      time_sum   = {1'b0, elapsed_ff} + (TIME_W+1)'(delta_ff);
      s_ext      = {{(SUM_W-SAMPLE_BITS){rd_data[SAMPLE_BITS-1]}}, rd_data};
   end

   always_comb begin
      avg_window_in = avg_window_ff;
      delay_in      = delay_ff;
      type_in       = type_ff;
      sample_in     = sample_ff;
      delta_in      = delta_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      pushes_in     = pushes_ff;
      elapsed_in    = elapsed_ff;
      n_in          = n_ff;
      len_in        = len_ff;
      refresh_in    = refresh_ff;
      rd_idx_in     = rd_idx_ff;
      pend_in       = rd_go;
      pend_idx_in   = rd_idx_ff;
      sum_run_in    = sum_run_ff;
      sum_all_in    = sum_all_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      last_avg_in   = last_avg_ff;
      shown_avg_in  = shown_avg_ff;
      shown_min_in  = shown_min_ff;
      shown_max_in  = shown_max_ff;
      updated_in    = updated_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_AVG_WINDOW:    avg_window_in = csr_wdata[AVG_W-1:0];
            CSR_DISPLAY_DELAY: delay_in      = csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         type_in    = req_type;
         sample_in  = req_sample;
         delta_in   = req_delta;
         updated_in = 1'b0;
      end

      if (cmd.tick && (count_ff != '0)) begin
         elapsed_in = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
      end

      if (cmd.store) begin
         pos_in     = pos_next;
         count_in   = count_inc;
         pushes_in  = pushes_inc;
         n_in       = n_calc;
         refresh_in = (elapsed_ff >= delay_ff) || (pushes_inc >= CNT_W'(WINDOW_DEPTH));
         len_in     = refresh_in ? count_inc : n_calc;
         rd_idx_in  = '0;
         sum_run_in = '0;
         sum_all_in = '0;
      end

      if (rd_go) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end

      if (pend_ff) begin
         sum_all_in = sum_all_ff + s_ext;
         if (pend_idx_ff < n_ff) begin
            sum_run_in = sum_run_ff + s_ext;
         end
         if ((pend_idx_ff == '0) || (rd_data < min_ff)) begin
            min_in = rd_data;
         end
         if ((pend_idx_ff == '0) || (rd_data > max_ff)) begin
            max_in = rd_data;
         end
      end

      if (cmd.run_save) begin
         last_avg_in = (n_ff == '0) ? '0 : div_q;
      end

      if (cmd.all_save) begin
         shown_avg_in = div_q;
         shown_min_in = min_ff;
         shown_max_in = max_ff;
         elapsed_in   = '0;
         pushes_in    = '0;
         updated_in   = 1'b1;
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({shown_max_ff, shown_min_ff, shown_avg_ff, last_avg_ff});
         rsp_user_in  = updated_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_window_ff <= AVG_WINDOW_RESET;
         delay_ff      <= DISPLAY_DELAY_RESET;
         pos_ff        <= '0;
         count_ff      <= '0;
         pushes_ff     <= '0;
         elapsed_ff    <= '0;
         pend_ff       <= 1'b0;
         last_avg_ff   <= '0;
         shown_avg_ff  <= '0;
         shown_min_ff  <= '0;
         shown_max_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         avg_window_ff <= avg_window_in;
         delay_ff      <= delay_in;
         pos_ff        <= pos_in;
         count_ff      <= count_in;
         pushes_ff     <= pushes_in;
         elapsed_ff    <= elapsed_in;
         pend_ff       <= pend_in;
         last_avg_ff   <= last_avg_in;
         shown_avg_ff  <= shown_avg_in;
         shown_min_ff  <= shown_min_in;
         shown_max_ff  <= shown_max_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      type_ff     <= type_in;
      sample_ff   <= sample_in;
      delta_ff    <= delta_in;
      n_ff        <= n_in;
      len_ff      <= len_in;
      refresh_ff  <= refresh_in;
      rd_idx_ff   <= rd_idx_in;
      pend_idx_ff <= pend_idx_in;
      sum_run_ff  <= sum_run_in;
      sum_all_ff  <= sum_all_in;
      min_ff      <= min_in;
      max_ff      <= max_in;
      updated_ff  <= updated_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_comb begin
      status.is_tick   = (type_ff == REQ_TICK);
      status.walk_done = (rd_idx_ff == len_ff) && !pend_ff;
      status.div_busy  = div_busy;
      status.refresh   = refresh_ff;
      status.out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WINDOW_DEPTH))
      else $error("stored count above window depth");

   a_pushes_bound: assert property (@(posedge clock) disable iff (reset)
      pushes_ff <= CNT_W'(WINDOW_DEPTH))
      else $error("push count above window depth");

   a_refresh_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.all_save |=> (pushes_ff == '0) && (elapsed_ff == '0) && updated_ff)
      else $error("refresh did not clear counters");

   a_read_stored: assert property (@(posedge clock) disable iff (reset)
      rd_go |-> (rd_idx_ff < count_ff))
      else $error("walk reads beyond stored samples");
`endif

endmodule
`default_nettype wire

// ===== rtl/wss_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed sample statistics controller
// Sequences a word at a time: tick, or store, walk, 1 or 2 divisions; result.
// ----------------------------------------------------------------------------
module wss_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire wss_pkg::status_type status,
   output wss_pkg::cmd_type         cmd
);
   import wss_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_TICK   = 4'd1;
   localparam logic [3:0] S_STORE  = 4'd2;
   localparam logic [3:0] S_WALK   = 4'd3;
   localparam logic [3:0] S_DIVR   = 4'd4;
   localparam logic [3:0] S_WAITR  = 4'd5;
   localparam logic [3:0] S_DIVA   = 4'd6;
   localparam logic [3:0] S_WAITA  = 4'd7;
   localparam logic [3:0] S_FINISH = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_TICK;
            end
         end
         S_TICK: begin
            if (status.is_tick) begin
               cmd.tick = 1'b1;
               state_in = S_FINISH;
            end else begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            cmd.store = 1'b1;
            state_in  = S_WALK;
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_done) begin
               state_in = S_DIVR;
            end
         end
         S_DIVR: begin
            cmd.div_start = 1'b1;
            state_in      = S_WAITR;
         end
         S_WAITR: begin
            if (!status.div_busy) begin
               cmd.run_save = 1'b1;
               state_in     = status.refresh ? S_DIVA : S_FINISH;
            end
         end
         S_DIVA: begin
            cmd.div_start   = 1'b1;
            cmd.div_sel_all = 1'b1;
            state_in        = S_WAITA;
         end
         S_WAITA: begin
            cmd.div_sel_all = 1'b1;
            if (!status.div_busy) begin
               cmd.all_save = 1'b1;
               state_in     = S_FINISH;
            end
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/windowed_sample_statistics.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed sample statistics
// Ring of the newest 64 samples with a running average and a periodically
// refreshed average, minimum and maximum over the whole stored window.
//
// req_ carries one word per item: tuser selects push (0) or tick (1), tdata
// holds the sample and the tick's time delta. Every word yields exactly one
// rsp_ word with the running average, the refresh flag and the shown values.
// csr_ writes avg_window (index 0) or display_delay (index 1);
// write only while no word is in flight.
// A tick passes from accept through its tick and finish states to the output
// register. A push walks its n samples, the newest min(avg_window, count) or
// all stored ones on a refresh, through the single RAM read port (one per
// cycle), then runs one or two divisions of 22 quotient steps on the shared
// divider. One word is in flight at a time; req_tready is high only while
// idle, from the cycle after the result loads, and a result waiting in the
// output register does not block the next accept. A stalled receiver holds
// the result and parks the next item at its last step. Reset clears the ring
// position, count, push and time counters, the shown values and the
// configuration to its defaults; the sample RAM is not cleared.
// ----------------------------------------------------------------------------
module windowed_sample_statistics (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [wss_pkg::REQ_DATA_W-1:0]     req_tdata,  // sample_value, delta_time
   input  wire logic                               req_tuser,  // req_type
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // running_average, displayed_average, displayed_minimum, displayed_maximum
   output logic      [wss_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                    rsp_tuser,  // display_updated
   input  wire logic                               csr_we,
   input  wire logic [wss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [wss_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import wss_pkg::*;

   cmd_type    cmd;
   status_type status;

   wss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   wss_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_type   (req_tuser),
      .req_sample (req_tdata[SAMPLE_BITS-1:0]),
      .req_delta  (req_tdata[SAMPLE_BITS+DELTA_W-1:SAMPLE_BITS]),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

// ===== dv/windowed_sample_statistics_tb.sv =====
// ----------------------------------------------------------------------------
// Windowed sample statistics testbench
// Streams sample pushes and time ticks into the block under random sender
// gaps and receiver stalls, rebuilds the running average and the refreshed
// average, minimum and maximum in a local predictor, and compares every
// result word field by field. Covers field extremes, a zero, a wide and an
// oversized averaging window, every-push refresh, refresh on a full round of
// pushes, and a run of the largest ticks at the largest delay.
// ----------------------------------------------------------------------------
module windowed_sample_statistics_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wss_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 150;
   localparam int MAX_REPORTS    = 10;
   localparam int PHASE_ITEMS    = 150;

   typedef struct packed {
      logic                          kind;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [DELTA_W-1:0]            delta;
   } stats_request_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] running;
      logic                          updated;
      logic signed [SAMPLE_BITS-1:0] average;
      logic signed [SAMPLE_BITS-1:0] minimum;
      logic signed [SAMPLE_BITS-1:0] maximum;
   } stats_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = REQ_PUSH;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_AVG_WINDOW;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   stats_request_type item_pending[$];
   stats_result_type  stats_expected[$];
   int unsigned    items_queued   = 0;
   int unsigned    results_seen   = 0;
   int unsigned    mismatch_count = 0;
   int unsigned    quiet_cycles   = 0;
   logic           req_taken      = 1'b0;
   logic           idle_off       = 1'b0;
   int             send_gap       = 0;
   int             recv_stall     = 0;

   logic signed [SAMPLE_BITS-1:0] ring [WINDOW_DEPTH];
   logic [ADDR_W-1:0]             ring_head     = '0;
   int unsigned                   ring_count    = 0;
   int unsigned                   since_refresh = 0;
   logic [TIME_W-1:0]             elapsed       = '0;
   logic signed [SAMPLE_BITS-1:0] last_running  = '0;
   logic signed [SAMPLE_BITS-1:0] shown_average = '0;
   logic signed [SAMPLE_BITS-1:0] shown_minimum = '0;
   logic signed [SAMPLE_BITS-1:0] shown_maximum = '0;
   logic [AVG_W-1:0]              cfg_window    = AVG_WINDOW_RESET;
   logic [TIME_W-1:0]             cfg_delay     = DISPLAY_DELAY_RESET;

   windowed_sample_statistics i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic signed [SAMPLE_BITS-1:0] window_mean(
      input  int unsigned                   n,
      output logic signed [SAMPLE_BITS-1:0] lo,
      output logic signed [SAMPLE_BITS-1:0] hi
   );
      longint                        total;
      logic signed [SAMPLE_BITS-1:0] s;
      logic [ADDR_W-1:0]             idx;
      total = 0;
      lo    = '0;
      hi    = '0;
      if (n > ring_count) n = ring_count;
      if (n == 0) return '0;
      for (int i = 0; i < n; i++) begin
         idx = ring_head - ADDR_W'(i);
         s   = ring[idx];
         total += s;
         if (i == 0 || s < lo) lo = s;
         if (i == 0 || s > hi) hi = s;
      end
      return SAMPLE_BITS'(total / longint'(n));
   endfunction

   function automatic stats_result_type predict_stats(input stats_request_type item);
      stats_result_type              r;
      logic signed [SAMPLE_BITS-1:0] lo;
      logic signed [SAMPLE_BITS-1:0] hi;
      logic [TIME_W:0]               grown;
      r.updated = 1'b0;
      if (item.kind == REQ_PUSH) begin
         ring_head       = ring_head + 1'b1;
         ring[ring_head] = item.sample;
         if (ring_count < WINDOW_DEPTH) ring_count++;
         last_running = window_mean(cfg_window, lo, hi);
         since_refresh++;
         if (elapsed >= cfg_delay || since_refresh >= WINDOW_DEPTH) begin
            shown_average = window_mean(WINDOW_DEPTH, lo, hi);
            shown_minimum = lo;
            shown_maximum = hi;
            elapsed       = '0;
            since_refresh = 0;
            r.updated     = 1'b1;
         end
      end else if (ring_count > 0) begin
         grown   = {1'b0, elapsed} + item.delta;
         elapsed = grown[TIME_W] ? '1 : grown[TIME_W-1:0];
      end
      r.running = last_running;
      r.average = shown_average;
      r.minimum = shown_minimum;
      r.maximum = shown_maximum;
      return r;
   endfunction

   function automatic int draw_gap();
      int roll;
      if (idle_off) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   task automatic enqueue(input logic kind, input logic [15:0] sample,
                          input logic [15:0] delta);
      stats_request_type item;
      item.kind   = kind;
      item.sample = sample;
      item.delta  = delta;
      item_pending.push_back(item);
      items_queued++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_AVG_WINDOW) cfg_window = value[AVG_W-1:0];
      else cfg_delay = value[TIME_W-1:0];
   endtask

   task automatic set_config(input logic [AVG_W-1:0] window, input logic [TIME_W-1:0] delay);
      write_reg(CSR_AVG_WINDOW, CSR_DATA_W'(window));
      write_reg(CSR_DISPLAY_DELAY, CSR_DATA_W'(delay));
   endtask

   task automatic wait_idle();
      wait (results_seen == items_queued);
      @(negedge clock);
   endtask

   // driver and receiver stalls
   always @(negedge clock) begin
      stats_request_type next_item;
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (send_gap > 0) begin
               send_gap   <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (item_pending.size() > 0) begin
               next_item   = item_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= next_item.kind;
               req_tdata  <= {next_item.delta, next_item.sample};
               send_gap   <= draw_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_stall <= draw_gap();
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      stats_request_type seen;
      stats_result_type  got;
      stats_result_type  want;
      if (reset) begin
         req_taken    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (req_tvalid && req_tready) begin
            seen.kind   = req_tuser;
            seen.sample = req_tdata[SAMPLE_BITS-1:0];
            seen.delta  = req_tdata[SAMPLE_BITS +: DELTA_W];
            stats_expected.push_back(predict_stats(seen));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.running = rsp_tdata[0 +: SAMPLE_BITS];
            got.updated = rsp_tuser;
            got.average = rsp_tdata[SAMPLE_BITS +: SAMPLE_BITS];
            got.minimum = rsp_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
            got.maximum = rsp_tdata[3*SAMPLE_BITS +: SAMPLE_BITS];
            if (stats_expected.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: result word with no pending item: run=%0d upd=%0b",
                           $realtime, got.running, got.updated);
            end else begin
               want = stats_expected.pop_front();
               if (want != got) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("%0t: word %0d expected run=%0d upd=%0b avg=%0d min=%0d max=%0d",
                              $realtime, results_seen, want.running, want.updated,
                              want.average, want.minimum, want.maximum);
                     $display("%0t: word %0d actual   run=%0d upd=%0b avg=%0d min=%0d max=%0d",
                              $realtime, results_seen, got.running, got.updated,
                              got.average, got.minimum, got.maximum);
                  end
               end
            end
            results_seen++;
         end
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      logic [AVG_W-1:0]  phase_window [8];
      logic [TIME_W-1:0] phase_delay  [8];
      logic [15:0]       value;
      logic [15:0]       delta;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults: tick before any sample, extremes, refresh on elapsed time
      enqueue(REQ_TICK, 16'($urandom), 16'hFFFF);
      enqueue(REQ_TICK, 16'($urandom), 16'h0000);
      enqueue(REQ_PUSH, 16'h7FFF, 16'($urandom));
      enqueue(REQ_PUSH, 16'h8000, 16'($urandom));
      enqueue(REQ_PUSH, 16'hFFFF, 16'($urandom));
      enqueue(REQ_PUSH, 16'h0000, 16'($urandom));
      enqueue(REQ_PUSH, 16'h0001, 16'($urandom));
      enqueue(REQ_TICK, 16'($urandom), 16'd999);
      enqueue(REQ_PUSH, 16'd5, 16'($urandom));
      enqueue(REQ_TICK, 16'($urandom), 16'd1);
      enqueue(REQ_PUSH, -16'sd5, 16'($urandom));
      wait_idle();

      // zero window, refresh on every push
      set_config('0, '0);
      enqueue(REQ_PUSH, 16'd100, 16'($urandom));
      enqueue(REQ_PUSH, -16'sd7, 16'($urandom));
      wait_idle();

      // window beyond the depth
      set_config('1, '0);
      repeat (3) enqueue(REQ_PUSH, 16'h7FFF, 16'($urandom));
      repeat (3) enqueue(REQ_PUSH, 16'h8000, 16'($urandom));
      enqueue(REQ_TICK, 16'($urandom), 16'hFFFF);
      wait_idle();

      // run of the largest ticks back to back at the largest delay
      set_config(AVG_W'(WINDOW_DEPTH), '1);
      idle_off = 1'b1;
      enqueue(REQ_PUSH, 16'd42, 16'($urandom));
      repeat (30) enqueue(REQ_TICK, 16'($urandom), 16'hFFFF);
      enqueue(REQ_PUSH, -16'sd42, 16'($urandom));
      wait_idle();
      idle_off = 1'b0;

      phase_window[0] = AVG_W'(1);
      phase_delay[0]  = 0;
      phase_window[1] = AVG_W'(WINDOW_DEPTH);
      phase_delay[1]  = '1;
      phase_window[2] = '0;
      phase_delay[2]  = 300;
      phase_window[3] = '1;
      phase_delay[3]  = 70000;
      phase_window[4] = AVG_W'(WINDOW_DEPTH + 1);
      phase_delay[4]  = 1;
      for (int p = 5; p < 8; p++) begin
         phase_window[p] = AVG_W'($urandom_range(1, WINDOW_DEPTH));
         phase_delay[p]  = $urandom_range(0, 200000);
      end

      for (int p = 0; p < 8; p++) begin
         idle_off = (p == 3 || p == 6);
         set_config(phase_window[p], phase_delay[p]);
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
               case ($urandom_range(0, 7))
                  0: begin
                     value = 16'h7FFF;
                  end
                  1: begin
                     value = 16'h8000;
                  end
                  2: begin
                     value = 16'($urandom_range(0, 200) - 100);
                  end
                  default: begin
                     value = 16'($urandom);
                  end
               endcase
               enqueue(REQ_PUSH, value, 16'($urandom));
            end else begin
               case ($urandom_range(0, 5))
                  0: begin
                     delta = 16'h0000;
                  end
                  1: begin
                     delta = 16'hFFFF;
                  end
                  2, 3: begin
                     delta = 16'($urandom_range(0, 400));
                  end
                  default: begin
                     delta = 16'($urandom);
                  end
               endcase
               enqueue(REQ_TICK, 16'($urandom), delta);
            end
         end
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      mismatch_count += stats_expected.size();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
